// ===== hw/rtl/fsmon_pkg.sv =====
// Shared types, constants and helpers of the frame sequence monitor.
package fsmon_pkg;

    // Frame size rules
    localparam int HEADER_BYTES = 128;
    localparam int SAMPLE_BYTES = 4;
    localparam int BAD_FLAG_BIT = 8;
    // Width of the required size: 32-bit count times 4, plus header
    localparam int NEED_W = 36;

    // Field widths
    localparam int SIZE_W = 20;
    localparam int SEQ_W  = 32;
    localparam int CNT_W  = 32;

    // Queue between the classifier and the sequence tracker
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = 1;
    localparam int CMDQ_CW    = 2;

    // Result queue in front of the result port
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_CW    = 3;

    // Result status codes
    typedef enum logic [2:0] {
        ST_GOOD    = 3'd0,
        ST_BAD     = 3'd1,
        ST_REORDER = 3'd2,
        ST_PASS    = 3'd3,
        ST_CLEAR   = 3'd4
    } status_t;

    // Item class decided at the front
    typedef enum logic [2:0] {
        CLS_CLEAR    = 3'd0,
        CLS_PASS     = 3'd1,
        CLS_BAD_MARK = 3'd2,
        CLS_BAD_SIZE = 3'd3,
        CLS_GOOD     = 3'd4
    } class_t;

    // Classified item held in the queue
    typedef struct packed {
        class_t             cls;
        logic [SIZE_W-1:0]  payload;
        logic [SEQ_W-1:0]   seq;
    } entry_t;

    // Counter update handed from the sequence tracker to the counters
    typedef struct packed {
        logic               clear;
        logic               inc_good;
        logic               inc_bad;
        logic               inc_reorder;
        logic               size_upd;
        logic [CNT_W-1:0]   gap;
        logic [SIZE_W-1:0]  payload;
        logic               forward;
        status_t            status;
    } upd_t;

    // One result item
    typedef struct packed {
        logic               forward;
        status_t            status;
        logic [CNT_W-1:0]   good;
        logic [CNT_W-1:0]   lost;
        logic [CNT_W-1:0]   reorder;
        logic [CNT_W-1:0]   bad;
        logic [SIZE_W-1:0]  last_payload;
    } result_t;

    // Saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== hw/rtl/fsmon_front.sv =====
// Front end: accepts items, holds the disable register and classifies each item.
module fsmon_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          cmd,
    input  logic                          frame_error,
    input  logic [15:0]                   frame_flags,
    input  logic [fsmon_pkg::SIZE_W-1:0]  payload_bytes,
    input  logic [31:0]                   channel_count,
    input  logic [fsmon_pkg::SEQ_W-1:0]   sequence_number,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          q_full,
    output logic                          q_push,
    output fsmon_pkg::entry_t             q_entry
);

    logic                          disable_reg;
    logic [fsmon_pkg::NEED_W-1:0]  need;
    logic [fsmon_pkg::NEED_W-1:0]  payload_ext;
    logic                          too_short;

    // Take configuration writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            disable_reg <= cfg_data;
        end
    end

    // Accept while the queue has room
    assign full   = q_full;
    assign q_push = push && !q_full;

    // Size check at full width
    assign need = fsmon_pkg::NEED_W'(fsmon_pkg::HEADER_BYTES)
                + fsmon_pkg::NEED_W'(channel_count) * fsmon_pkg::NEED_W'(fsmon_pkg::SAMPLE_BYTES);
    assign payload_ext = fsmon_pkg::NEED_W'(payload_bytes);
    assign too_short = (payload_ext < fsmon_pkg::NEED_W'(fsmon_pkg::HEADER_BYTES))
                    || (need > payload_ext);

    // Classify the item
    always_comb
    begin
        q_entry.payload = payload_bytes;
        q_entry.seq     = sequence_number;
        if (cmd)
        begin
            q_entry.cls = fsmon_pkg::CLS_CLEAR;
        end
        else if (disable_reg)
        begin
            q_entry.cls = fsmon_pkg::CLS_PASS;
        end
        else if (frame_error || frame_flags[fsmon_pkg::BAD_FLAG_BIT])
        begin
            q_entry.cls = fsmon_pkg::CLS_BAD_MARK;
        end
        else if (too_short)
        begin
            q_entry.cls = fsmon_pkg::CLS_BAD_SIZE;
        end
        else
        begin
            q_entry.cls = fsmon_pkg::CLS_GOOD;
        end
    end

endmodule

// ===== hw/rtl/fsmon_cmdq.sv =====
// Short queue of classified items between the front end and the back end.
module fsmon_cmdq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  fsmon_pkg::entry_t  wr_entry,
    output logic               full,
    input  logic               rd_en,
    output fsmon_pkg::entry_t  rd_entry,
    output logic               empty
);

    fsmon_pkg::entry_t               mem [fsmon_pkg::CMDQ_DEPTH];
    logic [fsmon_pkg::CMDQ_AW-1:0]   wr_ptr_reg;
    logic [fsmon_pkg::CMDQ_AW-1:0]   rd_ptr_reg;
    logic [fsmon_pkg::CMDQ_CW-1:0]   count_reg;
    logic [fsmon_pkg::CMDQ_CW-1:0]   count_next;
    logic                            do_wr;
    logic                            do_rd;

    assign full     = (count_reg == fsmon_pkg::CMDQ_CW'(fsmon_pkg::CMDQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && !empty;
    assign rd_entry = mem[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + fsmon_pkg::CMDQ_CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - fsmon_pkg::CMDQ_CW'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + fsmon_pkg::CMDQ_AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + fsmon_pkg::CMDQ_AW'(1);
            end
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== hw/rtl/fsmon_seq.sv =====
// Back end, first stage: tracks the sequence number and decides the counter update.
module fsmon_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  fsmon_pkg::entry_t  q_entry,
    output logic               q_pop,
    input  logic               room,
    output logic               upd_valid,
    output fsmon_pkg::upd_t    upd
);

    logic [fsmon_pkg::SEQ_W-1:0]  last_seq_reg;
    logic [fsmon_pkg::SEQ_W-1:0]  last_seq_next;
    logic                         awaiting_reg;
    logic                         awaiting_next;
    logic                         valid_reg;
    fsmon_pkg::upd_t              upd_reg;
    fsmon_pkg::upd_t              upd_next;
    logic                         fire;

    assign fire      = !q_empty && room;
    assign q_pop     = fire;
    assign upd_valid = valid_reg;
    assign upd       = upd_reg;

    // Decide status, gap and counter increments
    always_comb
    begin
        upd_next         = '0;
        upd_next.payload = q_entry.payload;
        upd_next.status  = fsmon_pkg::ST_PASS;
        last_seq_next    = last_seq_reg;
        awaiting_next    = awaiting_reg;
        case (q_entry.cls)
            fsmon_pkg::CLS_CLEAR:
            begin
                upd_next.clear  = 1'b1;
                upd_next.status = fsmon_pkg::ST_CLEAR;
            end
            fsmon_pkg::CLS_PASS:
            begin
                upd_next.forward = 1'b1;
                upd_next.status  = fsmon_pkg::ST_PASS;
            end
            fsmon_pkg::CLS_BAD_MARK:
            begin
                upd_next.inc_bad = 1'b1;
                upd_next.status  = fsmon_pkg::ST_BAD;
            end
            fsmon_pkg::CLS_BAD_SIZE:
            begin
                upd_next.inc_bad  = 1'b1;
                upd_next.size_upd = 1'b1;
                upd_next.status   = fsmon_pkg::ST_BAD;
            end
            fsmon_pkg::CLS_GOOD:
            begin
                upd_next.inc_good = 1'b1;
                upd_next.size_upd = 1'b1;
                upd_next.forward  = 1'b1;
                upd_next.status   = fsmon_pkg::ST_GOOD;
                last_seq_next     = q_entry.seq;
                if (awaiting_reg)
                begin
                    awaiting_next = 1'b0;
                end
                else if (q_entry.seq < last_seq_reg)
                begin
                    upd_next.inc_reorder = 1'b1;
                    upd_next.forward     = 1'b0;
                    upd_next.status      = fsmon_pkg::ST_REORDER;
                end
                else if (q_entry.seq > last_seq_reg)
                begin
                    upd_next.gap = q_entry.seq - last_seq_reg - fsmon_pkg::SEQ_W'(1);
                end
            end
            default:
            begin
                upd_next.status = fsmon_pkg::ST_PASS;
            end
        endcase
    end

    // Hold sequence state and stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            last_seq_reg <= '0;
            awaiting_reg <= 1'b1;
        end
        else
        begin
            valid_reg <= fire;
            if (fire)
            begin
                last_seq_reg <= last_seq_next;
                awaiting_reg <= awaiting_next;
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            upd_reg <= upd_next;
        end
    end

endmodule

// ===== hw/rtl/fsmon_count.sv =====
// Back end, second stage: saturating counters and the result queue.
module fsmon_count (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                upd_valid,
    input  fsmon_pkg::upd_t     upd,
    output logic                room,
    input  logic                pop,
    output logic                empty,
    output fsmon_pkg::result_t  result
);

    logic [fsmon_pkg::CNT_W-1:0]   good_reg;
    logic [fsmon_pkg::CNT_W-1:0]   lost_reg;
    logic [fsmon_pkg::CNT_W-1:0]   reorder_reg;
    logic [fsmon_pkg::CNT_W-1:0]   bad_reg;
    logic [fsmon_pkg::SIZE_W-1:0]  size_reg;
    logic [fsmon_pkg::CNT_W:0]     lost_sum;
    fsmon_pkg::result_t            res_next;

    fsmon_pkg::result_t            mem [fsmon_pkg::OUTQ_DEPTH];
    logic [fsmon_pkg::OUTQ_AW-1:0] wr_ptr_reg;
    logic [fsmon_pkg::OUTQ_AW-1:0] rd_ptr_reg;
    logic [fsmon_pkg::OUTQ_CW-1:0] count_reg;
    logic [fsmon_pkg::OUTQ_CW-1:0] count_next;
    logic                          do_rd;

    // Reserve a slot for the item still in the first stage
    assign room = (count_reg + fsmon_pkg::OUTQ_CW'(upd_valid))
                < fsmon_pkg::OUTQ_CW'(fsmon_pkg::OUTQ_DEPTH);

    // Apply the update with saturation
    assign lost_sum = {1'b0, lost_reg} + {1'b0, upd.gap};

    always_comb
    begin
        res_next.forward      = upd.forward;
        res_next.status       = upd.status;
        res_next.good         = upd.inc_good ? fsmon_pkg::sat_inc(good_reg) : good_reg;
        res_next.bad          = upd.inc_bad ? fsmon_pkg::sat_inc(bad_reg) : bad_reg;
        res_next.reorder      = upd.inc_reorder ? fsmon_pkg::sat_inc(reorder_reg) : reorder_reg;
        res_next.lost         = lost_sum[fsmon_pkg::CNT_W] ? '1 : lost_sum[fsmon_pkg::CNT_W-1:0];
        res_next.last_payload = upd.size_upd ? upd.payload : size_reg;
        if (upd.clear)
        begin
            res_next.good    = '0;
            res_next.bad     = '0;
            res_next.reorder = '0;
            res_next.lost    = '0;
        end
    end

    // Hold counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            good_reg    <= '0;
            lost_reg    <= '0;
            reorder_reg <= '0;
            bad_reg     <= '0;
            size_reg    <= '0;
        end
        else if (upd_valid)
        begin
            good_reg    <= res_next.good;
            lost_reg    <= res_next.lost;
            reorder_reg <= res_next.reorder;
            bad_reg     <= res_next.bad;
            size_reg    <= res_next.last_payload;
        end
    end

    // Result queue
    assign empty  = (count_reg == '0);
    assign do_rd  = pop && !empty;
    assign result = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (upd_valid && !do_rd)
        begin
            count_next = count_reg + fsmon_pkg::OUTQ_CW'(1);
        end
        else if (do_rd && !upd_valid)
        begin
            count_next = count_reg - fsmon_pkg::OUTQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (upd_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + fsmon_pkg::OUTQ_AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + fsmon_pkg::OUTQ_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_valid)
        begin
            mem[wr_ptr_reg] <= res_next;
        end
    end

endmodule

// ===== hw/rtl/frame_sequence_monitor_top.sv =====
// Top level of the frame sequence monitor: front end, item queue, back end.
//
//  channel   handshake             payload
//  -------   -------------------   ---------------------------------------------
//  input     push / full           cmd, frame_error, frame_flags, payload_bytes,
//                                  channel_count, sequence_number
//  result    empty / pop           forward, status, good_total, lost_total,
//                                  reorder_total, bad_total, last_payload_bytes
//  config    cfg_valid / cfg_ready cfg_data (monitor_disable)
//
// One item per cycle sustained while the result queue has room; a taken item
// passes the queue stage, then the sequence stage, then the counter update.
// The sequence compare and the loss addition sit in separate stages.
// Reset clears counters, sequence state, queues and the disable bit.
// A stalled result side fills the four-entry result queue, then the item
// queue, and only then raises full.
module frame_sequence_monitor_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          cmd,
    input  logic                          frame_error,
    input  logic [15:0]                   frame_flags,
    input  logic [fsmon_pkg::SIZE_W-1:0]  payload_bytes,
    input  logic [31:0]                   channel_count,
    input  logic [fsmon_pkg::SEQ_W-1:0]   sequence_number,
    output logic                          empty,
    input  logic                          pop,
    output logic                          forward,
    output logic [2:0]                    status,
    output logic [fsmon_pkg::CNT_W-1:0]   good_total,
    output logic [fsmon_pkg::CNT_W-1:0]   lost_total,
    output logic [fsmon_pkg::CNT_W-1:0]   reorder_total,
    output logic [fsmon_pkg::CNT_W-1:0]   bad_total,
    output logic [fsmon_pkg::SIZE_W-1:0]  last_payload_bytes,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);

    logic                q_full;
    logic                q_push;
    logic                q_empty;
    logic                q_pop;
    fsmon_pkg::entry_t   q_wr_entry;
    fsmon_pkg::entry_t   q_rd_entry;
    logic                room;
    logic                upd_valid;
    fsmon_pkg::upd_t     upd;
    fsmon_pkg::result_t  result;

    // Accept and classify
    fsmon_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .cmd             (cmd),
        .frame_error     (frame_error),
        .frame_flags     (frame_flags),
        .payload_bytes   (payload_bytes),
        .channel_count   (channel_count),
        .sequence_number (sequence_number),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (q_wr_entry)
    );

    // Decouple front and back
    fsmon_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_entry (q_rd_entry),
        .empty    (q_empty)
    );

    // Track sequence numbers
    fsmon_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_entry   (q_rd_entry),
        .q_pop     (q_pop),
        .room      (room),
        .upd_valid (upd_valid),
        .upd       (upd)
    );

    // Count and queue results
    fsmon_count u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd_valid (upd_valid),
        .upd       (upd),
        .room      (room),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    // Drive result ports
    assign forward            = result.forward;
    assign status             = result.status;
    assign good_total         = result.good;
    assign lost_total         = result.lost;
    assign reorder_total      = result.reorder;
    assign bad_total          = result.bad;
    assign last_payload_bytes = result.last_payload;

    // A cleared result shows all four counters at zero
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == fsmon_pkg::ST_CLEAR) |->
        (good_total == '0 && lost_total == '0 && reorder_total == '0 && bad_total == '0))
        else $error("cleared result with nonzero counters");

    // Forward only for good or passed items
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (forward == (status == fsmon_pkg::ST_GOOD || status == fsmon_pkg::ST_PASS)))
        else $error("forward does not match status");

    // Counters never fall between results unless cleared
    a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty) ##1 (!empty && status != fsmon_pkg::ST_CLEAR) |->
        (good_total >= $past(good_total) && bad_total >= $past(bad_total)
         && lost_total >= $past(lost_total) && reorder_total >= $past(reorder_total)))
        else $error("counter decreased without clear");

endmodule
